// File: design/bst_pkg.sv
// shared types, token codes and keyword tables for the byte stream tokenizer
package bst_pkg;

	localparam int TOK_KIND_W = 5;
	localparam int TOK_POS_W  = 16;
	localparam int NUM_KW     = 5;

	localparam logic [TOK_KIND_W-1:0] K_EOF     = 5'd0;
	localparam logic [TOK_KIND_W-1:0] K_PLUS    = 5'd1;
	localparam logic [TOK_KIND_W-1:0] K_MINUS   = 5'd2;
	localparam logic [TOK_KIND_W-1:0] K_STAR    = 5'd3;
	localparam logic [TOK_KIND_W-1:0] K_SLASH   = 5'd4;
	localparam logic [TOK_KIND_W-1:0] K_SEMI    = 5'd5;
	localparam logic [TOK_KIND_W-1:0] K_LPAREN  = 5'd6;
	localparam logic [TOK_KIND_W-1:0] K_RPAREN  = 5'd7;
	localparam logic [TOK_KIND_W-1:0] K_LBRACE  = 5'd8;
	localparam logic [TOK_KIND_W-1:0] K_RBRACE  = 5'd9;
	localparam logic [TOK_KIND_W-1:0] K_EQUAL   = 5'd10;
	localparam logic [TOK_KIND_W-1:0] K_ASSIGN  = 5'd11;
	localparam logic [TOK_KIND_W-1:0] K_GREATER = 5'd12;
	localparam logic [TOK_KIND_W-1:0] K_LESS    = 5'd13;
	localparam logic [TOK_KIND_W-1:0] K_NUMBER  = 5'd14;
	localparam logic [TOK_KIND_W-1:0] K_IDENT   = 5'd15;
	localparam logic [TOK_KIND_W-1:0] K_KW0     = 5'd16;
	localparam logic [TOK_KIND_W-1:0] K_INVALID = 5'd21;

	typedef enum logic [1:0] {
		P_NONE  = 2'd0,
		P_NUM   = 2'd1,
		P_IDENT = 2'd2,
		P_EQ    = 2'd3
	} pend_t;

	typedef struct packed {
		logic                  space;
		logic                  digit;
		logic                  alpha;
		logic                  eq;
		logic                  op;
		logic [TOK_KIND_W-1:0] op_kind;
	} cls_t;

	typedef struct packed {
		logic [TOK_KIND_W-1:0] kind;
		logic [TOK_POS_W-1:0]  start;
		logic [TOK_POS_W-1:0]  length;
		logic [7:0]            bad;
		logic                  last;
	} tok_t;

	// keyword lengths: letbro, ifbro, elsebro, whilebro, printbro
	function automatic logic [3:0] kw_len(input int unsigned k);
		logic [3:0] r;
		case (k)
			0: r = 4'd6;
			1: r = 4'd5;
			2: r = 4'd7;
			3: r = 4'd8;
			4: r = 4'd8;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] i);
		logic [63:0] s;
		case (k)
			0: s = {"letbro", 16'h0};
			1: s = {"ifbro", 24'h0};
			2: s = {"elsebro", 8'h0};
			3: s = "whilebro";
			4: s = "printbro";
			default: s = 64'h0;
		endcase
		return s[63 - 8*i -: 8];
	endfunction

endpackage

// File: design/bst_classify.sv
// character class decode for one source byte
module bst_classify (
	input  logic [7:0]    ch,
	output bst_pkg::cls_t cls
);
	import bst_pkg::*;

	always_comb begin
		cls = '0;
		cls.space = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
		cls.digit = (ch >= "0" && ch <= "9");
		cls.alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
		cls.eq    = (ch == "=");
		cls.op    = 1'b1;
		case (ch)
			"+": cls.op_kind = K_PLUS;
			"-": cls.op_kind = K_MINUS;
			"*": cls.op_kind = K_STAR;
			"/": cls.op_kind = K_SLASH;
			";": cls.op_kind = K_SEMI;
			"(": cls.op_kind = K_LPAREN;
			")": cls.op_kind = K_RPAREN;
			"{": cls.op_kind = K_LBRACE;
			"}": cls.op_kind = K_RBRACE;
			">": cls.op_kind = K_GREATER;
			"<": cls.op_kind = K_LESS;
			default: begin
				cls.op      = 1'b0;
				cls.op_kind = K_INVALID;
			end
		endcase
	end

endmodule

// File: design/bst_tokq.sv
// four-entry token queue, up to two writes and one read per cycle
module bst_tokq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_a,
	input  logic          push_b,
	input  bst_pkg::tok_t data_a,
	input  bst_pkg::tok_t data_b,
	input  logic          pop,
	output bst_pkg::tok_t head,
	output logic [2:0]    count
);
	import bst_pkg::*;

	tok_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [2:0] n_push;

	assign n_push = {2'b00, push_a} + {2'b00, push_b};
	assign head   = mem_q[rd_q];
	assign count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[1:0];
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + n_push - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) mem_q[wr_q] <= data_a;
		if (push_b) mem_q[wr_q + 2'd1] <= data_b;
	end

endmodule

// File: design/byte_stream_tokenizer.sv
// top level of the byte stream tokenizer: input register, token logic, token queue
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------------
//  source  | src_valid / src_ready   | source_byte, end_of_source, first_byte
//  token   | tok_valid / tok_ready   | token_kind, token_start, token_length,
//          |                         | invalid_char, last_of_run
//
//  one source request per cycle unless stalled; a request is registered, decoded and its
//  zero, one or two tokens land in a four-entry queue, which drains one token a cycle
//  while tok_ready is high; that sets the rate when requests give two tokens
//  arst_n clears position, pending token, keyword bits, end-of-file flag and the queue
//  a request waits in the input register while fewer than two queue slots are free
module byte_stream_tokenizer #(
	parameter int POSITION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_ready,
	input  logic [7:0]                       source_byte,
	input  logic                             end_of_source,
	input  logic                             first_byte,
	output logic                             tok_valid,
	input  logic                             tok_ready,
	output logic [bst_pkg::TOK_KIND_W-1:0]   token_kind,
	output logic [bst_pkg::TOK_POS_W-1:0]    token_start,
	output logic [bst_pkg::TOK_POS_W-1:0]    token_length,
	output logic [7:0]                       invalid_char,
	output logic                             last_of_run
);
	import bst_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
	localparam logic [NUM_KW-1:0] LIVE_ALL = {NUM_KW{1'b1}};

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       first_s1;

	// tokenizer state
	logic [PB-1:0]     pos_q;
	pend_t             pkind_q;
	logic [PB-1:0]     pstart_q;
	logic [PB-1:0]     plen_q;
	logic [NUM_KW-1:0] live_q;
	logic              fin_q;

	// state as seen by this request, after a restart if first_byte is set
	logic [PB-1:0]     e_pos, e_start, e_len;
	pend_t             e_kind;
	logic [NUM_KW-1:0] e_live;
	logic              e_fin;

	logic [PB-1:0]     nx_pos, nx_start, nx_len;
	pend_t             nx_kind;
	logic [NUM_KW-1:0] nx_live;
	logic              nx_fin;

	cls_t              cls;
	logic              advance;
	logic [2:0]        q_count;
	logic              push_a, push_b;
	tok_t              res_a, res_b, close_tok, fresh_tok, head;
	logic              close_v, fresh_v;
	logic [NUM_KW-1:0] trk_live, first_live;
	logic [TOK_KIND_W-1:0] id_kind;

	function automatic logic [TOK_POS_W-1:0] sat16(input logic [PB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	bst_classify u_cls (
		.ch  (byte_s1),
		.cls (cls)
	);

	// a request leaves the input register only when two queue slots are free
	assign advance   = valid_s1 && (q_count <= 3'd2);
	assign src_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			byte_s1  <= source_byte;
			eos_s1   <= end_of_source;
			first_s1 <= first_byte;
		end
	end

	// restart view
	always_comb begin
		if (first_s1) begin
			e_pos   = '0;
			e_kind  = P_NONE;
			e_start = '0;
			e_len   = '0;
			e_live  = LIVE_ALL;
			e_fin   = 1'b0;
		end else begin
			e_pos   = pos_q;
			e_kind  = pkind_q;
			e_start = pstart_q;
			e_len   = plen_q;
			e_live  = live_q;
			e_fin   = fin_q;
		end
	end

	// keyword match tracking, all five compared in parallel
	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			trk_live[k] = e_live[k] && (32'(e_len) < 32'(kw_len(k)))
				&& (kw_char(k, e_len[2:0]) == byte_s1);
			first_live[k] = (kw_char(k, 3'd0) == byte_s1);
		end
	end

	// identifier kind on close, first live keyword of full length wins
	always_comb begin
		id_kind = K_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (e_live[k] && (32'(e_len) == 32'(kw_len(k))))
				id_kind = K_KW0 + TOK_KIND_W'(k);
		end
	end

	// token for a pending run being closed
	always_comb begin
		close_tok       = '0;
		close_tok.start = sat16(e_start);
		close_tok.length = sat16(e_len);
		close_v         = (e_kind != P_NONE);
		case (e_kind)
			P_NUM:   close_tok.kind = K_NUMBER;
			P_IDENT: close_tok.kind = id_kind;
			P_EQ: begin
				close_tok.kind   = K_ASSIGN;
				close_tok.length = 16'd1;
			end
			default: close_tok.kind = K_EOF;
		endcase
	end

	// single-byte token when the byte starts afresh
	always_comb begin
		fresh_tok        = '0;
		fresh_tok.start  = sat16(e_pos);
		fresh_tok.length = 16'd1;
		fresh_v          = 1'b0;
		if (cls.op) begin
			fresh_v        = 1'b1;
			fresh_tok.kind = cls.op_kind;
		end else if (!cls.space && !cls.eq && !cls.digit && !cls.alpha) begin
			fresh_v        = 1'b1;
			fresh_tok.kind = K_INVALID;
			fresh_tok.bad  = byte_s1;
		end
	end

	// main decision for one request
	always_comb begin
		nx_pos   = e_pos;
		nx_kind  = e_kind;
		nx_start = e_start;
		nx_len   = e_len;
		nx_live  = e_live;
		nx_fin   = e_fin;
		push_a   = 1'b0;
		push_b   = 1'b0;
		res_a    = close_tok;
		res_b    = '0;
		if (!e_fin) begin
			if (eos_s1 || byte_s1 == 8'd0) begin
				// close anything pending, then end of file
				res_b.kind  = K_EOF;
				res_b.start = sat16(e_pos);
				if (close_v) begin
					push_a = 1'b1;
					push_b = 1'b1;
				end else begin
					res_a  = res_b;
					push_a = 1'b1;
				end
				nx_kind = P_NONE;
				nx_len  = '0;
				nx_live = LIVE_ALL;
				nx_fin  = 1'b1;
			end else if (e_kind == P_NUM && cls.digit) begin
				if (e_len != POS_MAX) nx_len = e_len + 1'b1;
			end else if (e_kind == P_IDENT && (cls.alpha || cls.digit)) begin
				nx_live = trk_live;
				if (e_len != POS_MAX) nx_len = e_len + 1'b1;
			end else if (e_kind == P_EQ && cls.eq) begin
				res_a.kind   = K_EQUAL;
				res_a.length = 16'd2;
				push_a       = 1'b1;
				nx_kind      = P_NONE;
				nx_len       = '0;
			end else begin
				nx_kind = P_NONE;
				nx_len  = '0;
				nx_live = LIVE_ALL;
				if (close_v && fresh_v) begin
					push_a = 1'b1;
					push_b = 1'b1;
					res_b  = fresh_tok;
				end else if (close_v) begin
					push_a = 1'b1;
				end else if (fresh_v) begin
					push_a = 1'b1;
					res_a  = fresh_tok;
				end
				// the byte may open a new run
				if (cls.eq || cls.digit || cls.alpha) begin
					nx_start = e_pos;
					nx_len   = PB'(1);
					if (cls.eq) begin
						nx_kind = P_EQ;
					end else if (cls.digit) begin
						nx_kind = P_NUM;
					end else begin
						nx_kind = P_IDENT;
						nx_live = first_live;
					end
				end
			end
			if (!nx_fin && e_pos != POS_MAX) nx_pos = e_pos + 1'b1;
		end
		// mark the last token of this request
		if (push_b) res_b.last = 1'b1;
		else        res_a.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pkind_q  <= P_NONE;
			pstart_q <= '0;
			plen_q   <= '0;
			live_q   <= LIVE_ALL;
			fin_q    <= 1'b0;
		end else if (advance) begin
			pos_q    <= nx_pos;
			pkind_q  <= nx_kind;
			pstart_q <= nx_start;
			plen_q   <= nx_len;
			live_q   <= nx_live;
			fin_q    <= nx_fin;
		end
	end

	bst_tokq u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (advance && push_a),
		.push_b (advance && push_b),
		.data_a (res_a),
		.data_b (res_b),
		.pop    (tok_valid && tok_ready),
		.head   (head),
		.count  (q_count)
	);

	assign tok_valid    = (q_count != 3'd0);
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign invalid_char = head.bad;
	assign last_of_run  = head.last;

endmodule

// File: design/bst_checker.sv
// port-level checks for the byte stream tokenizer, bound to the top level
module bst_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           tok_valid,
	input logic                           tok_ready,
	input logic [bst_pkg::TOK_KIND_W-1:0] token_kind,
	input logic [bst_pkg::TOK_POS_W-1:0]  token_start,
	input logic [bst_pkg::TOK_POS_W-1:0]  token_length,
	input logic [7:0]                     invalid_char,
	input logic                           last_of_run
);
	import bst_pkg::*;

	// a waiting token holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(token_kind)
			&& $stable(token_start) && $stable(token_length))
		else $error("token changed while stalled");

	// end of file is the only zero-length token and always closes its request
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((token_kind == K_EOF) == (token_length == 16'd0))
			&& (token_kind != K_EOF || last_of_run))
		else $error("end of file length or last flag wrong");

	// offending byte shows only on invalid tokens, which are one byte long
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (token_kind == K_INVALID)
			? (invalid_char != 8'd0 && token_length == 16'd1) : (invalid_char == 8'd0))
		else $error("invalid byte field wrong");

	// a token that is not last is followed by the rest of its request
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready && !last_of_run |=> tok_valid)
		else $error("second token of a request missing");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tok_valid    (tok_valid),
	.tok_ready    (tok_ready),
	.token_kind   (token_kind),
	.token_start  (token_start),
	.token_length (token_length),
	.invalid_char (invalid_char),
	.last_of_run  (last_of_run)
);

// File: tb/token_check.sv
// token checker for the byte stream tokenizer: predicts tokens from source requests and compares
`timescale 1ns / 1ps
module token_check #(
	parameter int POSITION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	input  logic                           src_ready,
	input  logic [7:0]                     source_byte,
	input  logic                           end_of_source,
	input  logic                           first_byte,
	input  logic                           tok_valid,
	input  logic                           tok_ready,
	input  logic [bst_pkg::TOK_KIND_W-1:0] token_kind,
	input  logic [bst_pkg::TOK_POS_W-1:0]  token_start,
	input  logic [bst_pkg::TOK_POS_W-1:0]  token_length,
	input  logic [7:0]                     invalid_char,
	input  logic                           last_of_run,
	output int                             mismatches,
	output int                             outstanding
);
	import bst_pkg::*;

	localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 64'd1;

	string keyword_text [NUM_KW] = '{"letbro", "ifbro", "elsebro", "whilebro", "printbro"};

	longint unsigned     position;
	longint unsigned     open_start;
	longint unsigned     open_length;
	pend_t               open_kind;
	logic [NUM_KW-1:0]   keyword_live;
	logic                source_done;
	tok_t                expected_tokens [$];
	tok_t                run_tokens [$];
	int                  errors;

	function automatic logic [15:0] clip16(input longint unsigned v);
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void add_token(input logic [4:0] kind, input longint unsigned start,
			input longint unsigned len, input logic [7:0] bad);
		tok_t t;
		t.kind   = kind;
		t.start  = clip16(start);
		t.length = clip16(len);
		t.bad    = bad;
		t.last   = 1'b0;
		run_tokens.push_back(t);
	endfunction

	function automatic void clear_source();
		position     = 0;
		open_kind    = P_NONE;
		open_start   = 0;
		open_length  = 0;
		keyword_live = '1;
		source_done  = 1'b0;
	endfunction

	function automatic void open_token(input pend_t kind);
		open_kind    = kind;
		open_start   = position;
		open_length  = 0;
		keyword_live = '1;
	endfunction

	// drop keywords that no longer match at the current word offset
	function automatic void match_keywords(input logic [7:0] c);
		for (int k = 0; k < NUM_KW; k++)
			if (open_length >= keyword_text[k].len() || keyword_text[k][int'(open_length)] != c)
				keyword_live[k] = 1'b0;
	endfunction

	function automatic void close_open();
		logic [4:0] kind;
		case (open_kind)
			P_NUM: add_token(K_NUMBER, open_start, open_length, 8'h00);
			P_IDENT: begin
				kind = K_IDENT;
				// descending, so the lowest matching keyword wins
				for (int k = NUM_KW - 1; k >= 0; k--)
					if (keyword_live[k] && open_length == keyword_text[k].len())
						kind = K_KW0 + 5'(k);
				add_token(kind, open_start, open_length, 8'h00);
			end
			P_EQ: add_token(K_ASSIGN, open_start, 1, 8'h00);
			default: ;
		endcase
		open_kind    = P_NONE;
		open_length  = 0;
		keyword_live = '1;
	endfunction

	function automatic void start_byte(input logic [7:0] c);
		logic [4:0] kind;
		kind = K_INVALID;
		case (c)
			"+": kind = K_PLUS;
			"-": kind = K_MINUS;
			"*": kind = K_STAR;
			"/": kind = K_SLASH;
			";": kind = K_SEMI;
			"(": kind = K_LPAREN;
			")": kind = K_RPAREN;
			"{": kind = K_LBRACE;
			"}": kind = K_RBRACE;
			">": kind = K_GREATER;
			"<": kind = K_LESS;
			default: ;
		endcase
		if (c == " " || (c >= 8'd9 && c <= 8'd13))
			return;
		if (c == "=") begin
			open_token(P_EQ);
			open_length = 1;
		end else if (is_digit(c)) begin
			open_token(P_NUM);
			open_length = 1;
		end else if (is_letter(c)) begin
			open_token(P_IDENT);
			match_keywords(c);
			open_length = 1;
		end else if (kind == K_INVALID) begin
			add_token(K_INVALID, position, 1, c);
		end else begin
			add_token(kind, position, 1, 8'h00);
		end
	endfunction

	function automatic void tokenize_byte(input logic [7:0] c, input logic eos, input logic fb);
		run_tokens.delete();
		if (fb)
			clear_source();
		if (source_done)
			return;
		if (eos || c == 8'h00) begin
			close_open();
			add_token(K_EOF, position, 0, 8'h00);
			source_done = 1'b1;
		end else if (open_kind == P_NUM && is_digit(c)) begin
			if (open_length < POS_MAX) open_length++;
		end else if (open_kind == P_IDENT && (is_letter(c) || is_digit(c))) begin
			match_keywords(c);
			if (open_length < POS_MAX) open_length++;
		end else if (open_kind == P_EQ && c == "=") begin
			add_token(K_EQUAL, open_start, 2, 8'h00);
			open_kind   = P_NONE;
			open_length = 0;
		end else begin
			close_open();
			start_byte(c);
		end
		if (!source_done && position < POS_MAX)
			position++;
		if (run_tokens.size() > 0)
			run_tokens[run_tokens.size() - 1].last = 1'b1;
		foreach (run_tokens[i])
			expected_tokens.push_back(run_tokens[i]);
	endfunction

	function automatic void check_token();
		tok_t want;
		if (expected_tokens.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t unexpected token: kind %0d start %0d length %0d char %0d last %0d",
					$time, token_kind, token_start, token_length, invalid_char, last_of_run);
			return;
		end
		want = expected_tokens.pop_front();
		if (token_kind !== want.kind || token_start !== want.start ||
				token_length !== want.length || invalid_char !== want.bad ||
				last_of_run !== want.last) begin
			errors++;
			// fields in order: kind, start, length, char, last
			if (errors <= 10)
				$display("%0t mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
					$time, want.kind, want.start, want.length, want.bad, want.last,
					token_kind, token_start, token_length, invalid_char, last_of_run);
		end
	endfunction

	// tokens leave first: a token seen with a request in the same cycle is never from it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_source();
			expected_tokens.delete();
			errors = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (tok_valid && tok_ready)
				check_token();
			if (src_valid && src_ready)
				tokenize_byte(source_byte, end_of_source, first_byte);
			mismatches  <= errors;
			outstanding <= expected_tokens.size();
		end
	end

endmodule

// File: tb/testbench.sv
// testbench top for the byte stream tokenizer: clock, reset, source requests and verdict
`timescale 1ns / 1ps
module testbench;

	// cycles with neither a request nor a token accepted before the run is declared hung
	localparam int IDLE_LIMIT    = 2000;
	// random requests that count towards the run length
	localparam int ITEM_TARGET   = 1750;
	// the last stretch of the run goes without any idling
	localparam int CALM_TAIL     = 250;
	// input register plus the queue, with margin
	localparam int SETTLE_CYCLES = 10;
	// a word well past every keyword length
	localparam int LONG_WORD     = 40;

	logic                           clk;
	logic                           arst_n;
	logic                           src_valid;
	logic                           src_ready;
	logic [7:0]                     source_byte;
	logic                           end_of_source;
	logic                           first_byte;
	logic                           tok_valid;
	logic                           tok_ready;
	logic [bst_pkg::TOK_KIND_W-1:0] token_kind;
	logic [bst_pkg::TOK_POS_W-1:0]  token_start;
	logic [bst_pkg::TOK_POS_W-1:0]  token_length;
	logic [7:0]                     invalid_char;
	logic                           last_of_run;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	int ready_hold  = 0;
	int items_sent  = 0;
	bit idling      = 1'b0;
	// the next request opens a new source
	bit restart_next = 1'b0;

	string keywords [bst_pkg::NUM_KW] = '{"letbro", "ifbro", "elsebro", "whilebro", "printbro"};
	// space, tab, newline, vertical tab, form feed, carriage return
	logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	byte_stream_tokenizer #(
		.POSITION_BITS(16)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.source_byte  (source_byte),
		.end_of_source(end_of_source),
		.first_byte   (first_byte),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.invalid_char (invalid_char),
		.last_of_run  (last_of_run)
	);

	token_check #(
		.POSITION_BITS(16)
	) tok_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.source_byte  (source_byte),
		.end_of_source(end_of_source),
		.first_byte   (first_byte),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.invalid_char (invalid_char),
		.last_of_run  (last_of_run),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// token sink: while idling is on, ready drops at random for a randomly drawn hold
	initial begin
		tok_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				tok_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				ready_hold = $urandom_range(0, 16);
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= 1'b1;
			end
		end
	end

	// hang detection: any accepted request or token restarts the count
	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (tok_valid && tok_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one request; ready is sampled on the falling edge, where it has settled
	task automatic send(input logic [7:0] b, input logic eos, input logic fb);
		logic seen;
		if (idling && $urandom_range(0, 9) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		src_valid     <= 1'b1;
		source_byte   <= b;
		end_of_source <= eos;
		first_byte    <= fb;
		do begin
			@(negedge clk);
			seen = src_ready;
			@(posedge clk);
		end while (!seen);
	endtask

	// one source character, carrying the restart mark if a new source is due
	task automatic put(input logic [7:0] b);
		send(b, 1'b0, restart_next);
		restart_next = 1'b0;
		items_sent++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	// hold the source back until every predicted token has been taken
	task automatic drain();
		src_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic put_blanks();
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
		repeat (n) put(blanks[$urandom_range(0, 5)]);
	endtask

	// letters and digits starting with a letter, or a plain digit run
	function automatic string random_word(input bit digits_only);
		string s;
		int n;
		logic [7:0] c;
		s = "";
		n = digits_only ? $urandom_range(1, 6) : $urandom_range(1, 9);
		for (int i = 0; i < n; i++) begin
			if (digits_only || (i > 0 && $urandom_range(0, 3) == 0))
				c = 8'("0" + $urandom_range(0, 9));
			else if ($urandom_range(0, 1))
				c = 8'("a" + $urandom_range(0, 25));
			else
				c = 8'("A" + $urandom_range(0, 25));
			s = {s, "-"};
			s[i] = c;
		end
		return s;
	endfunction

	// a byte that is neither blank, word character nor operator
	function automatic logic [7:0] odd_byte();
		logic [7:0] b;
		string ops;
		bit known;
		ops = "+-*/;(){}<>=";
		if ($urandom_range(0, 1))
			return 8'($urandom_range(128, 255));
		do begin
			b = 8'($urandom_range(1, 127));
			known = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
				(b >= "A" && b <= "Z") || b == " " || (b >= 8'd9 && b <= 8'd13);
			for (int i = 0; i < ops.len(); i++)
				if (ops[i] == b) known = 1'b1;
		end while (known);
		return b;
	endfunction

	// keywords and near misses weigh heavily so the live-match tracking gets exercised
	function automatic string pick_lexeme();
		string s;
		string ops;
		ops = "+-*/;(){}<>";
		s = keywords[$urandom_range(0, bst_pkg::NUM_KW - 1)];
		case ($urandom_range(0, 11))
			0, 1: ;                                    // exact keyword
			2: s = s.substr(0, s.len() - 2);           // keyword one short
			3: begin                                   // keyword one too long
				s = {s, "-"};
				s[s.len() - 1] = ($urandom_range(0, 1)) ? 8'("a" + $urandom_range(0, 25))
					: 8'("0" + $urandom_range(0, 9));
			end
			4: s[$urandom_range(0, s.len() - 1)] = "q"; // one letter off
			5: s[0] = s[0] - 8'd32;                    // capitalised
			6, 11: s = random_word(1'b0);
			7: s = random_word(1'b1);
			8: begin
				s = "+";
				s[0] = ops[$urandom_range(0, ops.len() - 1)];
			end
			9: s = ($urandom_range(0, 1)) ? "==" : "=";
			default: begin
				s = "!";
				s[0] = odd_byte();
			end
		endcase
		return s;
	endfunction

	// a well-formed source with random content; a truncated one never reaches end of file
	task automatic send_program(input bit truncated);
		int n_lexemes;
		restart_next = 1'b1;
		n_lexemes = $urandom_range(2, 14);
		for (int i = 0; i < n_lexemes; i++) begin
			put_blanks();
			put_text(pick_lexeme());
		end
		if (!truncated) begin
			put_blanks();
			if ($urandom_range(0, 1)) begin
				put(8'h00);
			end else begin
				send(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				items_sent++;
			end
			// trailing requests after end of file are dropped by the block
			repeat ($urandom_range(0, 3))
				send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		src_valid     <= 1'b0;
		source_byte   <= 8'h00;
		end_of_source <= 1'b0;
		first_byte    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operator, equality and assign, invalid bytes, all blanks
		send("+", 1'b0, 1'b1);
		put_text("-*/;(){}<>");
		// equality, then an assign closed by a letter, which opens a word
		put_text("===x");
		// the word is closed by a high byte, so one request gives two tokens
		put(8'hFF);
		put(8'h80);
		for (int i = 0; i < 6; i++)
			put(blanks[i]);
		// nul ends the source, the next byte is ignored
		put(8'h00);
		put("a");
		// restart carrying its own end of source: end of file at position zero
		send(8'hFF, 1'b1, 1'b1);
		// end flag with a nonzero byte closes a pending number
		restart_next = 1'b1;
		put_text("42");
		send(8'h41, 1'b1, 1'b0);
		drain();

		// one long word, far beyond every keyword, then an operator and a number
		restart_next = 1'b1;
		repeat (LONG_WORD) put("z");
		put_text("+12");
		send(8'h00, 1'b1, 1'b0);
		drain();

		// random part: mostly whole sources, some truncated, some raw noise
		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			idling = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(5, 30)) begin
					send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0),
						1'($urandom_range(0, 11) == 0));
					items_sent++;
				end
			end else begin
				send_program($urandom_range(0, 9) == 0);
			end
			if ($urandom_range(0, 11) == 0)
				drain();
		end
		idling = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
design/bst_pkg.sv
design/bst_classify.sv
design/bst_tokq.sv
design/byte_stream_tokenizer.sv
design/bst_checker.sv
tb/token_check.sv
tb/testbench.sv
